### hw/rtl/aaq_pkg.sv
`timescale 1ns / 1ps
// Package for the amplifier alarm qualifier: transfer payload types,
// threshold register map and qualification constants. No dependencies.
package aaq_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned SWR_CNT_W   = 4;
   localparam int unsigned TEMP_CNT_W  = 6;

   localparam logic signed [15:0]      SWR_MIN_FWD   = 16'sd300;
   localparam logic [SWR_CNT_W-1:0]    SWR_FWD_LIMIT = 4'd10;
   localparam logic [TEMP_CNT_W-1:0]   TEMP_LIMIT    = 6'd60;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SWR_CRITICAL  = 3'd0,
      REG_SWR_WARNING   = 3'd1,
      REG_FWD_CRITICAL  = 3'd2,
      REG_FWD_WARNING   = 3'd3,
      REG_TEMP_LOW_CRIT = 3'd4,
      REG_TEMP_LOW_WARN = 3'd5,
      REG_TEMP_HIGH_WARN = 3'd6,
      REG_TEMP_HIGH_CRIT = 3'd7
   } csr_index_type;

   localparam logic signed [15:0] TEMP_LOW_WARNING_RST   = 16'sd10;
   localparam logic signed [15:0] TEMP_HIGH_WARNING_RST  = 16'sd75;
   localparam logic signed [15:0] TEMP_HIGH_CRITICAL_RST = 16'sd80;

   typedef struct packed {
      logic signed [15:0] swr_critical_threshold;
      logic signed [15:0] swr_warning_threshold;
      logic signed [15:0] fwd_critical_threshold;
      logic signed [15:0] fwd_warning_threshold;
      logic signed [15:0] temp_low_critical;
      logic signed [15:0] temp_low_warning;
      logic signed [15:0] temp_high_warning;
      logic signed [15:0] temp_high_critical;
   } thr_type;

   typedef struct packed {
      logic signed [15:0] swr_reading;
      logic signed [15:0] fwd_power;
      logic signed [15:0] temperature;
      logic               recently_on;
      logic               standby;
   } req_type;

   typedef struct packed {
      logic swr_warning;
      logic swr_critical;
      logic fwd_warning;
      logic fwd_critical;
      logic temp_warning;
      logic temp_critical;
      logic any_critical;
      logic any_warning;
      logic attenuate_max;
   } rsp_type;

   // SWR qualifier status towards the output stage and the temperature unit
   typedef struct packed {
      logic warning;
      logic critical;
      logic attenuate;
      logic clr_temp_warning;
   } swr_stat_type;

   typedef struct packed {
      logic warning;
      logic critical;
   } alarm_pair_type;

endpackage

### hw/rtl/aaq_swr_qual.sv
`timescale 1ns / 1ps
// SWR qualifier: class counters, alarm bits and critical latch.
// Depends on aaq_pkg.
module aaq_swr_qual (
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  logic signed [15:0]  swr_reading,
   input  logic signed [15:0]  fwd_power,
   input  logic                recently_on,
   input  logic signed [15:0]  crit_thr,
   input  logic signed [15:0]  warn_thr,
   output aaq_pkg::swr_stat_type stat
);

   logic [aaq_pkg::SWR_CNT_W-1:0] crit_cnt_ff, crit_cnt_in;
   logic [aaq_pkg::SWR_CNT_W-1:0] warn_cnt_ff, warn_cnt_in;
   logic [aaq_pkg::SWR_CNT_W-1:0] ok_cnt_ff, ok_cnt_in;
   logic warn_ff, warn_in, crit_ff, crit_in, latch_ff, latch_in;
   logic fwd_ok, crit_hit, warn_hit, ok_hit, en;

   assign en       = update && !recently_on;
   assign fwd_ok   = fwd_power > aaq_pkg::SWR_MIN_FWD;
   assign crit_hit = (swr_reading < crit_thr) && fwd_ok;
   assign warn_hit = !crit_hit && (swr_reading < warn_thr) && fwd_ok;
   assign ok_hit   = !crit_hit && !warn_hit && (swr_reading >= warn_thr);

   always_comb begin
      crit_cnt_in = crit_cnt_ff;
      warn_cnt_in = warn_cnt_ff;
      ok_cnt_in   = ok_cnt_ff;
      warn_in     = warn_ff;
      crit_in     = crit_ff;
      latch_in    = latch_ff;
      stat.attenuate        = 1'b0;
      stat.clr_temp_warning = 1'b0;
      if (en) begin
         priority if (crit_hit) begin
            warn_cnt_in = '0;
            ok_cnt_in   = '0;
            if (crit_cnt_ff < aaq_pkg::SWR_FWD_LIMIT) begin
               crit_cnt_in = crit_cnt_ff + 1'b1;
            end else begin
               crit_in  = 1'b1;
               warn_in  = 1'b0;
               latch_in = 1'b1;
               stat.attenuate        = 1'b1;
               stat.clr_temp_warning = !latch_ff;
            end
         end else if (warn_hit) begin
            crit_cnt_in = '0;
            ok_cnt_in   = '0;
            if (warn_cnt_ff < aaq_pkg::SWR_FWD_LIMIT) begin
               warn_cnt_in = warn_cnt_ff + 1'b1;
            end else begin
               warn_in  = 1'b1;
               crit_in  = 1'b0;
               latch_in = 1'b0;
            end
         end else if (ok_hit) begin
            crit_cnt_in = '0;
            warn_cnt_in = '0;
            if (ok_cnt_ff < aaq_pkg::SWR_FWD_LIMIT) begin
               ok_cnt_in = ok_cnt_ff + 1'b1;
            end else begin
               warn_in  = 1'b0;
               crit_in  = 1'b0;
               latch_in = 1'b0;
            end
         end else begin
         end
      end
      stat.warning  = warn_in;
      stat.critical = crit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crit_cnt_ff <= '0;
         warn_cnt_ff <= '0;
         ok_cnt_ff   <= '0;
         warn_ff     <= 1'b0;
         crit_ff     <= 1'b0;
         latch_ff    <= 1'b0;
      end else begin
         crit_cnt_ff <= crit_cnt_in;
         warn_cnt_ff <= warn_cnt_in;
         ok_cnt_ff   <= ok_cnt_in;
         warn_ff     <= warn_in;
         crit_ff     <= crit_in;
         latch_ff    <= latch_in;
      end
   end

endmodule

### hw/rtl/aaq_fwd_qual.sv
`timescale 1ns / 1ps
// Forward power qualifier: class counters and alarm bits, standby clear.
// Depends on aaq_pkg.
module aaq_fwd_qual (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic signed [15:0]    fwd_power,
   input  logic                  recently_on,
   input  logic                  standby,
   input  logic signed [15:0]    crit_thr,
   input  logic signed [15:0]    warn_thr,
   output aaq_pkg::alarm_pair_type alarm
);

   logic [aaq_pkg::SWR_CNT_W-1:0] crit_cnt_ff, crit_cnt_in;
   logic [aaq_pkg::SWR_CNT_W-1:0] warn_cnt_ff, warn_cnt_in;
   logic [aaq_pkg::SWR_CNT_W-1:0] ok_cnt_ff, ok_cnt_in;
   logic warn_ff, warn_in, crit_ff, crit_in;
   logic crit_cls, warn_cls;

   assign crit_cls = fwd_power < crit_thr;
   assign warn_cls = fwd_power < warn_thr;

   always_comb begin
      crit_cnt_in = crit_cnt_ff;
      warn_cnt_in = warn_cnt_ff;
      ok_cnt_in   = ok_cnt_ff;
      warn_in     = warn_ff;
      crit_in     = crit_ff;
      if (update && !recently_on) begin
         priority if (standby) begin
            warn_in = 1'b0;
            crit_in = 1'b0;
         end else if (crit_cls) begin
            warn_cnt_in = '0;
            ok_cnt_in   = '0;
            if (crit_cnt_ff < aaq_pkg::SWR_FWD_LIMIT) begin
               crit_cnt_in = crit_cnt_ff + 1'b1;
            end else begin
               crit_in = 1'b1;
               warn_in = 1'b0;
            end
         end else if (warn_cls) begin
            crit_cnt_in = '0;
            ok_cnt_in   = '0;
            if (warn_cnt_ff < aaq_pkg::SWR_FWD_LIMIT) begin
               warn_cnt_in = warn_cnt_ff + 1'b1;
            end else begin
               warn_in = 1'b1;
               crit_in = 1'b0;
            end
         end else begin
            crit_cnt_in = '0;
            warn_cnt_in = '0;
            if (ok_cnt_ff < aaq_pkg::SWR_FWD_LIMIT) begin
               ok_cnt_in = ok_cnt_ff + 1'b1;
            end else begin
               warn_in = 1'b0;
               crit_in = 1'b0;
            end
         end
      end
      alarm.warning  = warn_in;
      alarm.critical = crit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crit_cnt_ff <= '0;
         warn_cnt_ff <= '0;
         ok_cnt_ff   <= '0;
         warn_ff     <= 1'b0;
         crit_ff     <= 1'b0;
      end else begin
         crit_cnt_ff <= crit_cnt_in;
         warn_cnt_ff <= warn_cnt_in;
         ok_cnt_ff   <= ok_cnt_in;
         warn_ff     <= warn_in;
         crit_ff     <= crit_in;
      end
   end

endmodule

### hw/rtl/aaq_temp_qual.sv
`timescale 1ns / 1ps
// Temperature qualifier: window classes, saturating counters, alarm bits.
// Depends on aaq_pkg.
module aaq_temp_qual (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic signed [15:0]    temperature,
   input  logic                  clr_warning_cnt,
   input  aaq_pkg::thr_type      thr,
   output aaq_pkg::alarm_pair_type alarm
);

   logic [aaq_pkg::TEMP_CNT_W-1:0] crit_cnt_ff, crit_cnt_in;
   logic [aaq_pkg::TEMP_CNT_W-1:0] warn_cnt_ff, warn_cnt_in;
   logic [aaq_pkg::TEMP_CNT_W-1:0] ok_cnt_ff, ok_cnt_in;
   logic [aaq_pkg::TEMP_CNT_W-1:0] warn_base;
   logic warn_ff, warn_in, crit_ff, crit_in;
   logic crit_cls, warn_cls;

   assign crit_cls  = (temperature < thr.temp_low_critical) ||
                      (temperature > thr.temp_high_critical);
   assign warn_cls  = (temperature < thr.temp_low_warning) ||
                      (temperature > thr.temp_high_warning);
   assign warn_base = clr_warning_cnt ? '0 : warn_cnt_ff;

   always_comb begin
      crit_cnt_in = crit_cnt_ff;
      warn_cnt_in = warn_cnt_ff;
      ok_cnt_in   = ok_cnt_ff;
      warn_in     = warn_ff;
      crit_in     = crit_ff;
      if (update) begin
         priority if (crit_cls) begin
            warn_cnt_in = '0;
            ok_cnt_in   = '0;
            crit_cnt_in = (crit_cnt_ff < aaq_pkg::TEMP_LIMIT) ?
                          crit_cnt_ff + 1'b1 : crit_cnt_ff;
            if (crit_cnt_in == aaq_pkg::TEMP_LIMIT) begin
               crit_in = 1'b1;
               warn_in = 1'b0;
            end
         end else if (warn_cls) begin
            crit_cnt_in = '0;
            ok_cnt_in   = '0;
            warn_cnt_in = (warn_base < aaq_pkg::TEMP_LIMIT) ?
                          warn_base + 1'b1 : warn_base;
            if (warn_cnt_in == aaq_pkg::TEMP_LIMIT) begin
               warn_in = 1'b1;
               crit_in = 1'b0;
            end
         end else begin
            crit_cnt_in = '0;
            warn_cnt_in = '0;
            ok_cnt_in   = (ok_cnt_ff < aaq_pkg::TEMP_LIMIT) ?
                          ok_cnt_ff + 1'b1 : ok_cnt_ff;
            if (ok_cnt_in == aaq_pkg::TEMP_LIMIT) begin
               warn_in = 1'b0;
               crit_in = 1'b0;
            end
         end
      end
      alarm.warning  = warn_in;
      alarm.critical = crit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crit_cnt_ff <= '0;
         warn_cnt_ff <= '0;
         ok_cnt_ff   <= '0;
         warn_ff     <= 1'b0;
         crit_ff     <= 1'b0;
      end else begin
         crit_cnt_ff <= crit_cnt_in;
         warn_cnt_ff <= warn_cnt_in;
         ok_cnt_ff   <= ok_cnt_in;
         warn_ff     <= warn_in;
         crit_ff     <= crit_in;
      end
   end

endmodule

### hw/rtl/amplifier_alarm_qualifier_core.sv
`timescale 1ns / 1ps
// Amplifier alarm qualifier top level: threshold registers, input and result
// registers, three qualifiers. Depends on aaq_pkg and the aaq_*_qual modules.
//
//   channel | ports                        | moves
//   --------+------------------------------+-----------------------------------
//   request | req_valid req_ready req_data | one measurement set per transfer
//   result  | rsp_valid rsp_ready rsp_data | alarm bits, summaries, attenuation
//   csr     | csr_write_en csr_index csr_wdata | threshold write, no wait
//
// One set per cycle sustained while results are taken; rsp_valid rises once a set
// passes from the input register through qualifier logic into the result register.
// Qualifier state advances when an item moves from input to result register.
// A stalled result holds the input register; req_ready then drops once it fills.
// Reset clears counters and alarm bits and restores threshold defaults.
module amplifier_alarm_qualifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  aaq_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output aaq_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [aaq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aaq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   aaq_pkg::thr_type       thr_ff;
   aaq_pkg::req_type       s1_data_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   aaq_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic                   advance;
   aaq_pkg::swr_stat_type  swr_stat;
   aaq_pkg::alarm_pair_type fwd_alarm, temp_alarm;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.swr_critical_threshold <= '0;
         thr_ff.swr_warning_threshold  <= '0;
         thr_ff.fwd_critical_threshold <= '0;
         thr_ff.fwd_warning_threshold  <= '0;
         thr_ff.temp_low_critical      <= '0;
         thr_ff.temp_low_warning       <= aaq_pkg::TEMP_LOW_WARNING_RST;
         thr_ff.temp_high_warning      <= aaq_pkg::TEMP_HIGH_WARNING_RST;
         thr_ff.temp_high_critical     <= aaq_pkg::TEMP_HIGH_CRITICAL_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            aaq_pkg::REG_SWR_CRITICAL:   thr_ff.swr_critical_threshold <= csr_wdata;
            aaq_pkg::REG_SWR_WARNING:    thr_ff.swr_warning_threshold  <= csr_wdata;
            aaq_pkg::REG_FWD_CRITICAL:   thr_ff.fwd_critical_threshold <= csr_wdata;
            aaq_pkg::REG_FWD_WARNING:    thr_ff.fwd_warning_threshold  <= csr_wdata;
            aaq_pkg::REG_TEMP_LOW_CRIT:  thr_ff.temp_low_critical      <= csr_wdata;
            aaq_pkg::REG_TEMP_LOW_WARN:  thr_ff.temp_low_warning       <= csr_wdata;
            aaq_pkg::REG_TEMP_HIGH_WARN: thr_ff.temp_high_warning      <= csr_wdata;
            aaq_pkg::REG_TEMP_HIGH_CRIT: thr_ff.temp_high_critical     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   aaq_swr_qual u_swr (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .swr_reading (s1_data_ff.swr_reading),
      .fwd_power   (s1_data_ff.fwd_power),
      .recently_on (s1_data_ff.recently_on),
      .crit_thr    (thr_ff.swr_critical_threshold),
      .warn_thr    (thr_ff.swr_warning_threshold),
      .stat        (swr_stat)
   );

   aaq_fwd_qual u_fwd (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .fwd_power   (s1_data_ff.fwd_power),
      .recently_on (s1_data_ff.recently_on),
      .standby     (s1_data_ff.standby),
      .crit_thr    (thr_ff.fwd_critical_threshold),
      .warn_thr    (thr_ff.fwd_warning_threshold),
      .alarm       (fwd_alarm)
   );

   aaq_temp_qual u_temp (
      .clock           (clock),
      .reset           (reset),
      .update          (advance),
      .temperature     (s1_data_ff.temperature),
      .clr_warning_cnt (swr_stat.clr_temp_warning),
      .thr             (thr_ff),
      .alarm           (temp_alarm)
   );

   always_comb begin
      rsp_data_in.swr_warning   = swr_stat.warning;
      rsp_data_in.swr_critical  = swr_stat.critical;
      rsp_data_in.fwd_warning   = fwd_alarm.warning;
      rsp_data_in.fwd_critical  = fwd_alarm.critical;
      rsp_data_in.temp_warning  = temp_alarm.warning;
      rsp_data_in.temp_critical = temp_alarm.critical;
      rsp_data_in.any_critical  = swr_stat.critical | fwd_alarm.critical |
                                  temp_alarm.critical;
      rsp_data_in.any_warning   = swr_stat.warning | fwd_alarm.warning |
                                  temp_alarm.warning;
      rsp_data_in.attenuate_max = swr_stat.attenuate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### hw/rtl/aaq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the amplifier alarm qualifier, bound to the top level.
// Depends on aaq_pkg.
module aaq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input aaq_pkg::rsp_type                rsp_data
);

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.any_critical ==
                     (rsp_data.swr_critical | rsp_data.fwd_critical |
                      rsp_data.temp_critical)) &&
                    (rsp_data.any_warning ==
                     (rsp_data.swr_warning | rsp_data.fwd_warning |
                      rsp_data.temp_warning)))
      else $error("summary flags disagree with alarm bits");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.swr_warning && rsp_data.swr_critical) &&
                    !(rsp_data.fwd_warning && rsp_data.fwd_critical) &&
                    !(rsp_data.temp_warning && rsp_data.temp_critical))
      else $error("warning and critical both set for one sensor");

   a_atten: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.attenuate_max |-> rsp_data.swr_critical)
      else $error("attenuation without critical SWR alarm");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind amplifier_alarm_qualifier_core aaq_checker u_aaq_checker (.*);

### bench/tb_amplifier_alarm_qualifier_core.sv
`timescale 1ns / 1ps
// Testbench for amplifier_alarm_qualifier_core: streams measurement sets with random gaps
// and stalls, rewrites the thresholds between phases and checks every result transfer
// against its own alarm predictor. Depends on aaq_pkg and the qualifier RTL.
module tb_amplifier_alarm_qualifier_core;

   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 200;

   typedef enum logic [1:0] {GRADE_CRIT, GRADE_WARN, GRADE_OK, GRADE_NONE} grade_type;
   typedef enum {TUNE_RESET, TUNE_NOMINAL, TUNE_FLOOR, TUNE_CEILING, TUNE_SCRAMBLED} tune_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   aaq_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b1;
   aaq_pkg::rsp_type                rsp_data;
   logic                            csr_write_en = 1'b0;
   logic [aaq_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [aaq_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   logic signed [15:0]              thr_q [8];
   aaq_pkg::alarm_pair_type         swr_alarm, fwd_alarm, temp_alarm;
   logic [aaq_pkg::SWR_CNT_W-1:0]   swr_runs [3];
   logic [aaq_pkg::SWR_CNT_W-1:0]   fwd_runs [3];
   logic [aaq_pkg::TEMP_CNT_W-1:0]  temp_runs [3];
   logic                            swr_latched;

   aaq_pkg::rsp_type expected_alarms [$];
   int      mismatch_count = 0;
   int      results_checked = 0;
   int      items_sent = 0;
   int      cycle_count = 0;
   int      stall = 0;
   bit      steady = 1'b0;

   amplifier_alarm_qualifier_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   task automatic restore_model();
      thr_q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                aaq_pkg::TEMP_LOW_WARNING_RST, aaq_pkg::TEMP_HIGH_WARNING_RST,
                aaq_pkg::TEMP_HIGH_CRITICAL_RST};
      swr_alarm   = '0;
      fwd_alarm   = '0;
      temp_alarm  = '0;
      swr_runs    = '{default: '0};
      fwd_runs    = '{default: '0};
      temp_runs   = '{default: '0};
      swr_latched = 1'b0;
   endtask

   function automatic grade_type swr_grade(logic signed [15:0] swr, logic signed [15:0] fwd);
      if (swr < thr_q[aaq_pkg::REG_SWR_CRITICAL] && fwd > aaq_pkg::SWR_MIN_FWD)
         return GRADE_CRIT;
      if (swr < thr_q[aaq_pkg::REG_SWR_WARNING] && fwd > aaq_pkg::SWR_MIN_FWD)
         return GRADE_WARN;
      if (swr >= thr_q[aaq_pkg::REG_SWR_WARNING]) return GRADE_OK;
      return GRADE_NONE;
   endfunction

   function automatic grade_type fwd_grade(logic signed [15:0] fwd);
      if (fwd < thr_q[aaq_pkg::REG_FWD_CRITICAL]) return GRADE_CRIT;
      if (fwd < thr_q[aaq_pkg::REG_FWD_WARNING]) return GRADE_WARN;
      return GRADE_OK;
   endfunction

   function automatic grade_type temp_grade(logic signed [15:0] t);
      if (t < thr_q[aaq_pkg::REG_TEMP_LOW_CRIT] || t > thr_q[aaq_pkg::REG_TEMP_HIGH_CRIT])
         return GRADE_CRIT;
      if (t < thr_q[aaq_pkg::REG_TEMP_LOW_WARN] || t > thr_q[aaq_pkg::REG_TEMP_HIGH_WARN])
         return GRADE_WARN;
      return GRADE_OK;
   endfunction

   function automatic aaq_pkg::alarm_pair_type grade_pair(grade_type g);
      aaq_pkg::alarm_pair_type p;
      p.warning  = (g == GRADE_WARN);
      p.critical = (g == GRADE_CRIT);
      return p;
   endfunction

   function automatic aaq_pkg::rsp_type qualify_alarms(aaq_pkg::req_type m);
      aaq_pkg::rsp_type r;
      grade_type        g;
      logic             attenuate;
      attenuate = 1'b0;
      if (!m.recently_on) begin
         g = swr_grade(m.swr_reading, m.fwd_power);
         if (g != GRADE_NONE) begin
            for (int k = 0; k < 3; k++) begin
               if (k != g) swr_runs[k] = '0;
            end
            if (swr_runs[g] == aaq_pkg::SWR_FWD_LIMIT) begin
               swr_alarm = grade_pair(g);
               if (g == GRADE_CRIT) begin
                  attenuate = 1'b1;
                  if (!swr_latched) temp_runs[GRADE_WARN] = '0;
               end
               swr_latched = (g == GRADE_CRIT);
            end else begin
               swr_runs[g] = swr_runs[g] + 1'b1;
            end
         end
         if (m.standby) begin
            fwd_alarm = '0;
         end else begin
            g = fwd_grade(m.fwd_power);
            for (int k = 0; k < 3; k++) begin
               if (k != g) fwd_runs[k] = '0;
            end
            if (fwd_runs[g] == aaq_pkg::SWR_FWD_LIMIT) begin
               fwd_alarm = grade_pair(g);
            end else begin
               fwd_runs[g] = fwd_runs[g] + 1'b1;
            end
         end
      end
      g = temp_grade(m.temperature);
      for (int k = 0; k < 3; k++) begin
         if (k != g) temp_runs[k] = '0;
      end
      if (temp_runs[g] < aaq_pkg::TEMP_LIMIT) temp_runs[g] = temp_runs[g] + 1'b1;
      if (temp_runs[g] == aaq_pkg::TEMP_LIMIT) temp_alarm = grade_pair(g);

      r.swr_warning   = swr_alarm.warning;
      r.swr_critical  = swr_alarm.critical;
      r.fwd_warning   = fwd_alarm.warning;
      r.fwd_critical  = fwd_alarm.critical;
      r.temp_warning  = temp_alarm.warning;
      r.temp_critical = temp_alarm.critical;
      r.any_critical  = swr_alarm.critical | fwd_alarm.critical | temp_alarm.critical;
      r.any_warning   = swr_alarm.warning | fwd_alarm.warning | temp_alarm.warning;
      r.attenuate_max = attenuate;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic check_bit(string field, logic got, logic want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s: got %b, expected %b",
                                   results_checked, field, got, want));
      end
   endtask

   task automatic check_result(aaq_pkg::rsp_type got);
      aaq_pkg::rsp_type want;
      if (expected_alarms.size() == 0) begin
         report_mismatch("result transfer with nothing expected");
         return;
      end
      want = expected_alarms.pop_front();
      check_bit("swr_warning", got.swr_warning, want.swr_warning);
      check_bit("swr_critical", got.swr_critical, want.swr_critical);
      check_bit("fwd_warning", got.fwd_warning, want.fwd_warning);
      check_bit("fwd_critical", got.fwd_critical, want.fwd_critical);
      check_bit("temp_warning", got.temp_warning, want.temp_warning);
      check_bit("temp_critical", got.temp_critical, want.temp_critical);
      check_bit("any_critical", got.any_critical, want.any_critical);
      check_bit("any_warning", got.any_warning, want.any_warning);
      check_bit("attenuate_max", got.attenuate_max, want.attenuate_max);
      results_checked++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_result(rsp_data);
         stall = steady ? 0 : int'($urandom_range(0, 6));
         rsp_ready <= (stall == 0);
      end else if (stall > 0) begin
         stall = stall - 1;
         rsp_ready <= (stall == 0);
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_measurement(aaq_pkg::req_type m);
      int gap;
      gap = steady ? 0 : int'($urandom_range(0, 6));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_alarms.push_back(qualify_alarms(m));
      items_sent++;
   endtask

   task automatic send_fields(int swr, int fwd, int temp, logic recent, logic idle_stages);
      aaq_pkg::req_type m;
      m.swr_reading = 16'(swr);
      m.fwd_power   = 16'(fwd);
      m.temperature = 16'(temp);
      m.recently_on = recent;
      m.standby     = idle_stages;
      send_measurement(m);
   endtask

   task automatic send_noise();
      send_fields(int'($urandom), int'($urandom), int'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // drop valid, let every result transfer arrive
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_alarms.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_threshold(aaq_pkg::csr_index_type idx, logic signed [15:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      thr_q[idx] = value;
   endtask

   task automatic retune(tune_type kind);
      logic signed [15:0] t [8];
      int                 lo;
      case (kind)
         TUNE_RESET: begin
            t = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  aaq_pkg::TEMP_LOW_WARNING_RST, aaq_pkg::TEMP_HIGH_WARNING_RST,
                  aaq_pkg::TEMP_HIGH_CRITICAL_RST};
         end
         TUNE_FLOOR: begin
            foreach (t[k]) t[k] = 16'sh8000;
         end
         TUNE_CEILING: begin
            foreach (t[k]) t[k] = 16'sh7fff;
         end
         TUNE_SCRAMBLED: begin
            foreach (t[k]) t[k] = 16'($urandom);
         end
         default: begin
            lo = int'($urandom_range(0, 400)) - 200;
            t[aaq_pkg::REG_SWR_CRITICAL] = 16'(lo);
            t[aaq_pkg::REG_SWR_WARNING]  = 16'(lo + int'($urandom_range(1, 300)));
            lo = int'($urandom_range(0, 600)) - 100;
            t[aaq_pkg::REG_FWD_CRITICAL] = 16'(lo);
            t[aaq_pkg::REG_FWD_WARNING]  = 16'(lo + int'($urandom_range(1, 400)));
            lo = int'($urandom_range(0, 50)) - 40;
            t[aaq_pkg::REG_TEMP_LOW_CRIT] = 16'(lo);
            lo = lo + int'($urandom_range(1, 20));
            t[aaq_pkg::REG_TEMP_LOW_WARN] = 16'(lo);
            lo = lo + int'($urandom_range(1, 80));
            t[aaq_pkg::REG_TEMP_HIGH_WARN] = 16'(lo);
            lo = lo + int'($urandom_range(1, 20));
            t[aaq_pkg::REG_TEMP_HIGH_CRIT] = 16'(lo);
         end
      endcase
      for (int k = 0; k < 8; k++) write_threshold(aaq_pkg::csr_index_type'(k), t[k]);
   endtask

   function automatic tune_type draw_tune();
      case ($urandom_range(0, 9))
         0: return TUNE_RESET;
         1: return TUNE_FLOOR;
         2: return TUNE_CEILING;
         3: return TUNE_SCRAMBLED;
         default: return TUNE_NOMINAL;
      endcase
   endfunction

   function automatic logic signed [15:0] probe_value(logic signed [15:0] anchor);
      int offset;
      offset = int'($urandom_range(0, 64)) - 32;
      case ($urandom_range(0, 7))
         0: return 16'($urandom);
         1: return 16'sh8000;
         2: return 16'sh7fff;
         3: return anchor;
         default: return 16'(int'(anchor) + offset);
      endcase
   endfunction

   function automatic logic signed [15:0] pick_fwd(grade_type want, grade_type swr_want);
      logic signed [15:0] v;
      logic signed [15:0] anchor;
      logic               fits;
      v = '0;
      for (int k = 0; k < 40; k++) begin
         case ($urandom_range(0, 2))
            0: anchor = thr_q[aaq_pkg::REG_FWD_CRITICAL];
            1: anchor = thr_q[aaq_pkg::REG_FWD_WARNING];
            default: anchor = aaq_pkg::SWR_MIN_FWD;
         endcase
         v = probe_value(anchor);
         case (swr_want)
            GRADE_CRIT, GRADE_WARN: fits = (v > aaq_pkg::SWR_MIN_FWD);
            GRADE_NONE: fits = (v <= aaq_pkg::SWR_MIN_FWD);
            default: fits = 1'b1;
         endcase
         if (fits && fwd_grade(v) == want) return v;
      end
      return v;
   endfunction

   function automatic logic signed [15:0] pick_swr(grade_type want, logic signed [15:0] fwd);
      logic signed [15:0] v;
      v = '0;
      for (int k = 0; k < 40; k++) begin
         v = probe_value(thr_q[$urandom_range(0, 1)]);
         if (swr_grade(v, fwd) == want) return v;
      end
      return v;
   endfunction

   function automatic logic signed [15:0] pick_temp(grade_type want);
      logic signed [15:0] v;
      v = '0;
      for (int k = 0; k < 40; k++) begin
         v = probe_value(thr_q[$urandom_range(4, 7)]);
         if (temp_grade(v) == want) return v;
      end
      return v;
   endfunction

   task automatic send_run(grade_type swr_want, grade_type fwd_want, grade_type temp_want,
                           logic recent, logic idle_stages, int len);
      aaq_pkg::req_type m;
      repeat (len) begin
         m.fwd_power   = pick_fwd(fwd_want, swr_want);
         m.swr_reading = pick_swr(swr_want, m.fwd_power);
         m.temperature = pick_temp(temp_want);
         m.recently_on = recent;
         m.standby     = idle_stages;
         send_measurement(m);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_field_extremes();
      send_fields(0, 0, 50, 1'b0, 1'b0);
      send_fields(-32768, 32767, 32767, 1'b0, 1'b0);
      send_fields(32767, -32768, -32768, 1'b0, 1'b0);
      send_fields(-1, 301, 80, 1'b0, 1'b0);
      send_fields(-1, 300, 81, 1'b0, 1'b0);
      send_fields(0, 300, 75, 1'b0, 1'b0);
      send_fields(-1, 301, 76, 1'b1, 1'b0);
      send_fields(5, -1, 10, 1'b0, 1'b1);
      send_fields(-32768, -32768, 9, 1'b1, 1'b1);
      send_fields(32767, 32767, -1, 1'b0, 1'b0);
      send_fields(16'h5555, 16'h2aaa, 16'h5555, 1'b1, 1'b0);
      send_fields(16'haaaa, 16'hd555, 16'haaaa, 1'b0, 1'b1);
      send_fields(-32768, 301, 0, 1'b0, 1'b0);
      send_fields(-2, 302, 11, 1'b0, 1'b0);
      settle();
      retune(TUNE_FLOOR);
      send_fields(-32768, -32768, -32768, 1'b0, 1'b0);
      send_fields(32767, 32767, 32767, 1'b0, 1'b0);
      send_fields(-32767, 301, -32767, 1'b0, 1'b0);
      settle();
      retune(TUNE_CEILING);
      send_fields(32766, 301, 32767, 1'b0, 1'b0);
      send_fields(32767, 32767, 32766, 1'b0, 1'b0);
      send_fields(-32768, 300, -32768, 1'b0, 1'b1);
      settle();
   endtask

   task automatic test_swr_qualification();
      retune(TUNE_NOMINAL);
      send_run(GRADE_WARN, GRADE_OK, GRADE_OK, 1'b0, 1'b0, 12);
      send_run(GRADE_CRIT, GRADE_OK, GRADE_OK, 1'b0, 1'b0, 12);
      send_run(GRADE_NONE, GRADE_OK, GRADE_OK, 1'b0, 1'b0, 5);
      send_run(GRADE_OK, GRADE_OK, GRADE_OK, 1'b1, 1'b0, 4);
      send_run(GRADE_OK, GRADE_OK, GRADE_OK, 1'b0, 1'b0, 12);
      send_run(GRADE_CRIT, GRADE_OK, GRADE_OK, 1'b0, 1'b0, 3);
      send_run(GRADE_WARN, GRADE_OK, GRADE_OK, 1'b0, 1'b0, 12);
      // critical SWR landing in a temperature warning run restarts its count once
      send_run(GRADE_CRIT, GRADE_OK, GRADE_WARN, 1'b0, 1'b0, 40);
      send_run(GRADE_CRIT, GRADE_OK, GRADE_WARN, 1'b0, 1'b0, 40);
      send_run(GRADE_OK, GRADE_OK, GRADE_WARN, 1'b0, 1'b0, 12);
      send_run(GRADE_CRIT, GRADE_OK, GRADE_WARN, 1'b0, 1'b0, 14);
      settle();
   endtask

   task automatic test_fwd_qualification();
      retune(TUNE_NOMINAL);
      send_run(GRADE_OK, GRADE_CRIT, GRADE_OK, 1'b0, 1'b0, 12);
      send_run(GRADE_OK, GRADE_WARN, GRADE_OK, 1'b0, 1'b0, 12);
      send_run(GRADE_OK, GRADE_WARN, GRADE_OK, 1'b0, 1'b1, 3);
      send_run(GRADE_OK, GRADE_WARN, GRADE_OK, 1'b0, 1'b0, 2);
      send_run(GRADE_OK, GRADE_OK, GRADE_OK, 1'b0, 1'b0, 12);
      send_run(GRADE_OK, GRADE_CRIT, GRADE_OK, 1'b0, 1'b0, 12);
      send_run(GRADE_OK, GRADE_OK, GRADE_OK, 1'b1, 1'b1, 3);
      send_run(GRADE_OK, GRADE_OK, GRADE_OK, 1'b1, 1'b0, 3);
      settle();
   endtask

   task automatic test_temp_qualification();
      retune(TUNE_NOMINAL);
      steady = 1'b1;
      send_run(GRADE_OK, GRADE_OK, GRADE_CRIT, 1'b0, 1'b0, 62);
      steady = 1'b0;
      send_run(GRADE_OK, GRADE_OK, GRADE_WARN, 1'b0, 1'b0, 62);
      send_run(GRADE_OK, GRADE_OK, GRADE_OK, 1'b1, 1'b0, 62);
      settle();
   endtask

   task automatic test_random_runs();
      int goal;
      int run_len;
      int run_no;
      goal   = items_sent + RANDOM_ITEMS;
      run_no = 0;
      while (items_sent < goal) begin
         run_no++;
         if (run_no % 12 == 0) begin
            settle();
            retune(draw_tune());
         end
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_noise();
         end else begin
            run_len = ($urandom_range(0, 2) == 0) ? int'($urandom_range(55, 70))
                                                  : int'($urandom_range(1, 14));
            send_run(grade_type'($urandom_range(0, 3)), grade_type'($urandom_range(0, 2)),
                     grade_type'($urandom_range(0, 2)), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 5) == 0, run_len);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      restore_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_swr_qualification();
      test_fwd_qualification();
      test_temp_qualification();
      test_random_runs();
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
